// File: sv/string_bucket_hash_macros.svh
// Assertion helpers for string_bucket_hash
`ifndef STRING_BUCKET_HASH_MACROS_SVH
`define STRING_BUCKET_HASH_MACROS_SVH

// Same-cycle implication
`define SBH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sbh_pkg.sv
package sbh_pkg;

  localparam int unsigned KeyW    = 8;
  localparam int unsigned HashW   = 32;
  localparam int unsigned SizeW   = 31;
  localparam int unsigned CntW    = 6;
  localparam int unsigned DataOutW = 32;

  localparam logic [SizeW-1:0] SizeReset = 31'd256;
  localparam logic [SizeW-1:0] Fold8Lim  = 31'h100;
  localparam logic [SizeW-1:0] Fold16Lim = 31'h10000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } sbh_state_t;

  typedef struct packed {
    logic start;
  } sbh_mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sbh_mod_sts_t;

  function automatic logic [HashW-1:0] fold_hash(input logic [HashW-1:0] h,
                                                 input logic [SizeW-1:0] size);
    logic [HashW-1:0] f;
    f = h;
    if (size < Fold8Lim) begin
      f = {24'd0, h[7:0] ^ h[15:8] ^ h[23:16] ^ h[31:24]};
    end else if (size < Fold16Lim) begin
      f = {16'd0, h[15:0] ^ h[31:16]};
    end
    return f;
  endfunction

endpackage

// File: sv/string_bucket_hash.sv
// string_bucket_hash: sdbm string hash reduced to a bucket index.
// Input stream: one key byte per transaction on in_tdata; a zero byte ends
//   the key. Output stream: one bucket index per finished key on out_tdata.
// cfg_wr_en/cfg_wr_data set table_size (bucket count and fold select);
//   write it only while the block is idle.
// Nonzero bytes are taken one per cycle while in_tready is high and fold into the running hash.
// The zero byte starts a bit-serial remainder by table_size in the
//   subtract/compare unit; the remainder is then loaded into the output register.
// in_tready stays low while the remainder runs. A result waiting in the
//   output register does not block nonzero bytes; a finished remainder
//   waits in its unit until the output register frees up.
// A table_size of zero gives bucket 0.
// Reset (rst_n low, synchronous) clears the hash, empties the output,
//   and sets table_size to 256.
module string_bucket_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] key_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [30:0] bucket, [31] zero
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data   // [30:0] table_size
);

  `include "string_bucket_hash_macros.svh"

  sbh_pkg::sbh_state_t state_r, state_nxt;
  logic [sbh_pkg::SizeW-1:0] size_r;
  logic [sbh_pkg::SizeW-1:0] bucket_r, bucket_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic                      zero_r, zero_nxt;
  logic                      in_fire, out_fire, key_end, load;
  logic [sbh_pkg::HashW-1:0] hash;
  logic [sbh_pkg::SizeW-1:0] remainder;
  sbh_pkg::sbh_mod_ctl_t     mod_ctl;
  sbh_pkg::sbh_mod_sts_t     mod_sts;

  assign in_tready = (state_r == sbh_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;
  assign key_end   = in_fire && (in_tdata == '0);
  assign mod_ctl.start = key_end;

  sbh_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (in_fire && (in_tdata != '0)),
    .clr      (key_end),
    .key_byte (in_tdata),
    .hash     (hash)
  );

  sbh_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mod_ctl),
    .dividend  (sbh_pkg::fold_hash(hash, size_r)),
    .divisor   (size_r),
    .sts       (mod_sts),
    .remainder (remainder)
  );

  always_comb begin
    state_nxt = state_r;
    zero_nxt  = zero_r;
    load      = 1'b0;
    unique case (state_r)
      sbh_pkg::ST_IDLE: begin
        if (key_end) begin
          zero_nxt  = (size_r == '0);
          state_nxt = sbh_pkg::ST_DIV;
        end
      end
      sbh_pkg::ST_DIV: begin
        if (mod_sts.done) begin
          if (!out_vld_r || out_tready) begin
            load      = 1'b1;
            state_nxt = sbh_pkg::ST_IDLE;
          end else begin
            state_nxt = sbh_pkg::ST_HOLD;
          end
        end
      end
      sbh_pkg::ST_HOLD: begin
        if (!out_vld_r || out_tready) begin
          load      = 1'b1;
          state_nxt = sbh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbh_pkg::ST_IDLE;
    endcase
    bucket_nxt  = load ? (zero_r ? '0 : remainder) : bucket_r;
    out_vld_nxt = load || (out_vld_r && !out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sbh_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      size_r    <= sbh_pkg::SizeReset;
      zero_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      zero_r    <= zero_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bucket_r <= bucket_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(sbh_pkg::DataOutW-sbh_pkg::SizeW){1'b0}}, bucket_r};

  `SBH_ASSERT_NOW(a_busy_blocks_in, mod_sts.busy, !in_tready, "input ready while remainder runs")
  `SBH_ASSERT_NEXT(a_end_starts_div, key_end, mod_sts.busy, "key end did not start remainder")
  `SBH_ASSERT_NOW(a_bucket_range, out_vld_r && (size_r != '0), bucket_r < size_r, "bucket out of range")
  `SBH_ASSERT_NEXT(a_zero_size, load && zero_r, bucket_r == '0, "zero table size gave nonzero bucket")

endmodule

// File: sv/sbh_hash.sv
module sbh_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd_en,
  input  logic                        clr,
  input  logic [sbh_pkg::KeyW-1:0]    key_byte,
  output logic [sbh_pkg::HashW-1:0]   hash
);

  logic [sbh_pkg::HashW-1:0] hash_r;
  logic [sbh_pkg::HashW-1:0] hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (clr) begin
      hash_nxt = '0;
    end else if (upd_en) begin
      hash_nxt = {{(sbh_pkg::HashW-sbh_pkg::KeyW){1'b0}}, key_byte}
               + (hash_r << 6) + (hash_r << 16) - hash_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

// File: sv/sbh_mod.sv
// Restoring remainder, one dividend bit per cycle
module sbh_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sbh_pkg::sbh_mod_ctl_t       ctl,
  input  logic [sbh_pkg::HashW-1:0]   dividend,
  input  logic [sbh_pkg::SizeW-1:0]   divisor,
  output sbh_pkg::sbh_mod_sts_t       sts,
  output logic [sbh_pkg::SizeW-1:0]   remainder
);

  logic [sbh_pkg::HashW-1:0] dvd_r, dvd_nxt;
  logic [sbh_pkg::SizeW-1:0] dvs_r, dvs_nxt;
  logic [sbh_pkg::SizeW-1:0] rem_r, rem_nxt;
  logic [sbh_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [sbh_pkg::SizeW:0]   rem_sh;
  logic [sbh_pkg::SizeW:0]   rem_sub;

  assign rem_sh  = {rem_r, dvd_r[sbh_pkg::HashW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = sbh_pkg::CntW'(sbh_pkg::HashW);
    end else if (cnt_r != '0) begin
      dvd_nxt = dvd_r << 1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[sbh_pkg::SizeW-1:0];
      end else begin
        rem_nxt = rem_sh[sbh_pkg::SizeW-1:0];
      end
      cnt_nxt = cnt_r - sbh_pkg::CntW'(1);
      done_nxt = (cnt_r == sbh_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = (cnt_r != '0);
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

// File: tb/string_bucket_hash_test.sv
`timescale 1ns / 100ps

module string_bucket_hash_test;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [sbh_pkg::SizeW-1:0] SizeMax = '1;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_RARE_STALL
  } rx_style_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;   // [7:0] key_byte
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [31:0]       out_tdata;          // [30:0] bucket, [31] zero
  logic              cfg_wr_en   = 1'b0;
  logic [30:0]       cfg_wr_data = '0;   // [30:0] table_size

  logic [sbh_pkg::HashW-1:0]  key_hash     = '0;
  logic [sbh_pkg::SizeW-1:0]  table_size_q = sbh_pkg::SizeReset;
  logic [sbh_pkg::SizeW-1:0]  buckets_due[$];
  logic [sbh_pkg::SizeW-1:0]  bucket_exp;

  int unsigned       mismatches  = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left  = 0;
  int unsigned       tx_gap_max  = 0;
  int unsigned       rx_phase    = 0;
  rx_style_t         rx_style    = RX_ALWAYS;
  bit                rx_hold     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_bucket_hash i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic logic [sbh_pkg::HashW-1:0] sdbm_step(
      input logic [sbh_pkg::HashW-1:0] h,
      input logic [sbh_pkg::KeyW-1:0]  c);
    return sbh_pkg::HashW'(c) + (h << 6) + (h << 16) - h;
  endfunction

  function automatic logic [sbh_pkg::SizeW-1:0] sdbm_fold_bucket(
      input logic [sbh_pkg::HashW-1:0] h,
      input logic [sbh_pkg::SizeW-1:0] size);
    logic [sbh_pkg::HashW-1:0] folded;
    if (size < sbh_pkg::Fold8Lim) begin
      folded = sbh_pkg::HashW'(h[7:0] ^ h[15:8] ^ h[23:16] ^ h[31:24]);
    end else if (size < sbh_pkg::Fold16Lim) begin
      folded = sbh_pkg::HashW'(h[15:0] ^ h[31:16]);
    end else begin
      folded = h;
    end
    if (size == '0) begin
      return '0;
    end
    return sbh_pkg::SizeW'(folded % sbh_pkg::HashW'(size));
  endfunction

  function automatic void absorb_key_byte(input logic [sbh_pkg::KeyW-1:0] c);
    if (c != '0) begin
      key_hash = sdbm_step(key_hash, c);
    end else begin
      buckets_due.push_back(sdbm_fold_bucket(key_hash, table_size_q));
      key_hash = '0;
    end
  endfunction

  function automatic logic [sbh_pkg::SizeW-1:0] pick_table_size();
    logic [sbh_pkg::SizeW-1:0] edges[9];
    edges = '{31'd1, 31'd2, 31'd255, 31'd256, 31'd257,
              31'd65535, 31'd65536, 31'd65537, SizeMax};
    case ($urandom_range(0, 3))
      0:       return sbh_pkg::SizeW'($urandom_range(1, 255));
      1:       return sbh_pkg::SizeW'($urandom_range(256, 65535));
      2:       return sbh_pkg::SizeW'($urandom_range(65536, 32'h7fff_ffff));
      default: return edges[$urandom_range(0, 8)];
    endcase
  endfunction

  // one input transaction; valid stays high across a burst
  task automatic send_key_byte(input logic [sbh_pkg::KeyW-1:0] c);
    @(negedge clk);
    if (burst_left == 0) begin
      if (tx_gap_max != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    absorb_key_byte(c);
  endtask

  task automatic send_random_key(input int unsigned len);
    repeat (len) send_key_byte(sbh_pkg::KeyW'($urandom_range(1, 255)));
    send_key_byte('0);
  endtask

  task automatic drain_and_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (buckets_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [sbh_pkg::SizeW-1:0] size);
    drain_and_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    table_size_q = size;
  endtask

  task automatic test_directed();
    logic [sbh_pkg::SizeW-1:0] corner_sizes[6];
    corner_sizes = '{31'd1, 31'd255, 31'd65535, 31'd65536, SizeMax, 31'd0};
    send_key_byte('0);
    send_key_byte(8'hff);
    send_key_byte('0);
    send_key_byte(8'h01);
    send_key_byte(8'h80);
    send_key_byte(8'h7f);
    send_key_byte('0);
    foreach (corner_sizes[i]) begin
      set_table_size(corner_sizes[i]);
      send_key_byte(8'hff);
      send_key_byte(8'h5a);
      send_key_byte('0);
    end
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 10; phase++) begin
      set_table_size(pick_table_size());
      case ($urandom_range(0, 2))
        0:       tx_gap_max = 0;
        1:       tx_gap_max = 3;
        default: tx_gap_max = 10;
      endcase
      rx_style = rx_style_t'($urandom_range(0, 3));
      repeat (16) begin
        send_random_key($urandom_range(0, 12));
      end
    end
  endtask

  task automatic test_noise_bytes();
    set_table_size(pick_table_size());
    tx_gap_max = 4;
    rx_style   = RX_COIN;
    repeat (100) begin
      if ($urandom_range(0, 7) == 0) begin
        send_key_byte('0);
      end else begin
        send_key_byte(sbh_pkg::KeyW'($urandom));
      end
    end
    send_key_byte('0);
  endtask

  // receiver holds off while keys keep coming, so the block backs up
  task automatic test_backpressure();
    set_table_size(pick_table_size());
    tx_gap_max = 0;
    rx_style   = RX_ALWAYS;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (20) begin
      send_random_key($urandom_range(0, 4));
    end
  endtask

  always @(negedge clk) begin
    rx_phase++;
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS:   out_tready <= 1'b1;
        RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_tready <= (rx_phase % 7) > 2;
        default:     out_tready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (buckets_due.size() == 0) begin
        $error("bucket: no transaction expected, actual %0d",
               out_tdata[sbh_pkg::SizeW-1:0]);
        mismatches++;
      end else begin
        bucket_exp = buckets_due.pop_front();
        if (out_tdata[sbh_pkg::SizeW-1:0] !== bucket_exp) begin
          $error("bucket: expected %0d, actual %0d", bucket_exp,
                 out_tdata[sbh_pkg::SizeW-1:0]);
          mismatches++;
        end
        if (out_tdata[31] !== 1'b0) begin
          $error("pad: expected 0, actual %b", out_tdata[31]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_keys();
    test_noise_bytes();
    test_backpressure();
    drain_and_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/sbh_pkg.sv
sv/sbh_hash.sv
sv/sbh_mod.sv
sv/string_bucket_hash.sv
tb/string_bucket_hash_test.sv
